// ===== src/b64d_pkg.sv =====
// b64d_pkg: shared types, status codes and the character lookup for the
// Base64 stream decoder. No dependencies.
`default_nettype none

package b64d_pkg;

	// Status codes carried by the end-of-text item
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_LENGTH  = 2'd1;
	localparam logic [1:0] ST_BAD_PADDING = 2'd2;
	localparam logic [1:0] ST_BAD_CHAR    = 2'd3;

	localparam logic [7:0] PAD_CHAR = 8'h3d;

	// Depth of the command queue between front and back
	localparam int CMD_DEPTH = 4;

	// Work handed from front to back: up to three bytes and an optional status
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  nbytes;
		logic        has_status;
		logic [1:0]  status;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	// Base64 alphabet to 6-bit value
	function automatic sextet_t sextet_lookup(input logic [7:0] c);
		sextet_t r;
		r.valid = 1'b1;
		r.value = 6'd0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			r.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2b) begin
			r.value = 6'd62;
		end else if (c == 8'h2f) begin
			r.value = 6'd63;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/b64d_front.sv =====
// b64d_front: accepts characters, tracks group position, padding and faults,
// and issues commands to the back end. Depends on b64d_pkg.
`default_nettype none

module b64d_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire logic [7:0]     char_code,
	input  wire logic           last_char,
	input  wire logic           cmd_full,
	output logic                cmd_wr,
	output b64d_pkg::cmd_t      cmd_data
);

	logic [17:0] group_bits_q;
	logic [1:0]  pos_q;
	logic        pad_pending_q;
	logic [1:0]  fault_q;

	logic              accept;
	b64d_pkg::sextet_t sx;
	logic              is_pad;
	logic [1:0]        code;
	logic [1:0]        nbytes;
	logic [23:0]       word;
	logic [17:0]       group_bits_d;
	logic              pad_set;
	logic [1:0]        fault_d;
	logic [1:0]        pos_d;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign sx     = b64d_pkg::sextet_lookup(char_code);
	assign is_pad = (char_code == b64d_pkg::PAD_CHAR);
	assign pos_d  = pos_q + 2'd1;

	// Classify the character at its group position
	always_comb begin
		code         = b64d_pkg::ST_OK;
		nbytes       = 2'd0;
		word         = 24'd0;
		group_bits_d = group_bits_q;
		pad_set      = 1'b0;
		if (pos_q < 2'd2) begin
			if (is_pad) begin
				code = b64d_pkg::ST_BAD_PADDING;
			end else if (!sx.valid) begin
				code = b64d_pkg::ST_BAD_CHAR;
			end else begin
				group_bits_d = {group_bits_q[11:0], sx.value};
			end
		end else if (pos_q == 2'd2) begin
			if (is_pad) begin
				pad_set      = 1'b1;
				group_bits_d = {group_bits_q[11:0], 6'd0};
			end else if (!sx.valid) begin
				code = b64d_pkg::ST_BAD_CHAR;
			end else begin
				group_bits_d = {group_bits_q[11:0], sx.value};
			end
		end else begin
			word = {group_bits_q, 6'd0};
			if (pad_pending_q) begin
				if (is_pad && last_char) nbytes = 2'd1;
				else code = b64d_pkg::ST_BAD_PADDING;
			end else if (is_pad) begin
				if (last_char) nbytes = 2'd2;
				else code = b64d_pkg::ST_BAD_PADDING;
			end else if (!sx.valid) begin
				code = b64d_pkg::ST_BAD_CHAR;
			end else begin
				word   = {group_bits_q, sx.value};
				nbytes = 2'd3;
			end
		end
	end

	// First fault wins
	assign fault_d = (fault_q == b64d_pkg::ST_OK) ? code : fault_q;

	// Command to the back end; bytes are dropped once a fault is on record
	always_comb begin
		cmd_data.word       = word;
		cmd_data.nbytes     = (fault_d == b64d_pkg::ST_OK) ? nbytes : 2'd0;
		cmd_data.has_status = last_char;
		cmd_data.status     = (pos_d != 2'd0) ? b64d_pkg::ST_BAD_LENGTH : fault_d;
	end

	assign cmd_wr = accept && (last_char || (cmd_data.nbytes != 2'd0));

	// Decoder state; end of text returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_bits_q  <= 18'd0;
			pos_q         <= 2'd0;
			pad_pending_q <= 1'b0;
			fault_q       <= b64d_pkg::ST_OK;
		end else if (accept) begin
			if (last_char) begin
				group_bits_q  <= 18'd0;
				pos_q         <= 2'd0;
				pad_pending_q <= 1'b0;
				fault_q       <= b64d_pkg::ST_OK;
			end else begin
				pos_q   <= pos_d;
				fault_q <= fault_d;
				if (pos_q == 2'd3) begin
					group_bits_q  <= 18'd0;
					pad_pending_q <= 1'b0;
				end else begin
					group_bits_q  <= group_bits_d;
					pad_pending_q <= pad_pending_q | pad_set;
				end
			end
		end
	end

	// End of text leaves the group position at zero
	a_last_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_char |=> pos_q == 2'd0)
		else $error("group position not cleared after end of text");

	// A recorded fault holds until end of text
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_char && fault_q != b64d_pkg::ST_OK |=> fault_q == $past(fault_q))
		else $error("fault code changed before end of text");

	// Padding can only be pending at the last group position
	a_pad_pos: assert property (@(posedge clk) disable iff (!arst_n)
		pad_pending_q |-> pos_q == 2'd3)
		else $error("pad pending outside the last group position");

endmodule

`default_nettype wire

// ===== src/b64d_cmd_fifo.sv =====
// b64d_cmd_fifo: short queue of commands between front and back end.
// Depends on b64d_pkg.
`default_nettype none

module b64d_cmd_fifo #(
	parameter int DEPTH = b64d_pkg::CMD_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire b64d_pkg::cmd_t wr_data,
	output logic                full,
	input  wire logic           rd,
	output b64d_pkg::cmd_t      rd_data,
	output logic                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64d_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("command queue count out of range");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && empty))
		else $error("command queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + 1'b1)
		else $error("command queue count did not advance on write");

endmodule

`default_nettype wire

// ===== src/b64d_back.sv =====
// b64d_back: expands each command into byte items and an optional status
// item, one per cycle while the output is empty or popped, into an output register. Depends on b64d_pkg.
`default_nettype none

module b64d_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire b64d_pkg::cmd_t cmd,
	input  wire logic           cmd_empty,
	output logic                cmd_rd,
	output logic                empty,
	input  wire logic           pop,
	output logic [7:0]          out_byte,
	output logic                is_status,
	output logic [1:0]          status,
	output logic                run_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       is_status_q;
	logic [1:0] status_q;
	logic       run_last_q;

	logic [2:0] total;
	logic       last_of_cmd;
	logic       advance;
	logic       is_byte;
	logic [7:0] sel_byte;

	assign total       = {1'b0, cmd.nbytes} + {2'b00, cmd.has_status};
	assign last_of_cmd = ({1'b0, idx_q} + 3'd1) == total;
	assign advance     = !cmd_empty && (!out_valid_q || pop);
	assign cmd_rd      = advance && last_of_cmd;
	assign is_byte     = idx_q < cmd.nbytes;

	// Byte select, most significant first
	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = cmd.word[23:16];
			2'd1:    sel_byte = cmd.word[15:8];
			default: sel_byte = cmd.word[7:0];
		endcase
	end

	// Position within the current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (advance) begin
			idx_q <= last_of_cmd ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q      <= is_byte ? sel_byte : 8'd0;
			is_status_q <= !is_byte;
			status_q    <= is_byte ? b64d_pkg::ST_OK : cmd.status;
			run_last_q  <= last_of_cmd;
		end
	end

	assign empty     = !out_valid_q;
	assign out_byte  = byte_q;
	assign is_status = is_status_q;
	assign status    = status_q;
	assign run_last  = run_last_q;

endmodule

`default_nettype wire

// ===== src/base64_stream_decoder.sv =====
// base64_stream_decoder: top level, front end, command queue and back end.
// Depends on b64d_pkg, b64d_front, b64d_cmd_fifo, b64d_back.
// Path: an accepted character's command is written into the command queue, and its first result item
// is then registered in the output register, which drives the outputs.
// Throughput: one character per cycle while full is low; the back end issues one result item
// per cycle while the output is empty or popped, so a full group of four characters (three bytes)
// keeps pace, and a closing character with bytes plus status gives up to four result items.
// Reset: arst_n clears decoder state, queue and output valid flag asynchronously.
`default_nettype none

module base64_stream_decoder #(
	parameter int CMD_DEPTH = b64d_pkg::CMD_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            is_status,
	output logic [1:0]      status,
	output logic            run_last
);

	b64d_pkg::cmd_t wr_cmd;
	b64d_pkg::cmd_t rd_cmd;
	logic           cmd_wr;
	logic           cmd_rd;
	logic           cmd_full;
	logic           cmd_empty;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_code (char_code),
		.last_char (last_char),
		.cmd_full  (cmd_full),
		.cmd_wr    (cmd_wr),
		.cmd_data  (wr_cmd)
	);

	b64d_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_wr),
		.wr_data (wr_cmd),
		.full    (cmd_full),
		.rd      (cmd_rd),
		.rd_data (rd_cmd),
		.empty   (cmd_empty)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rd_cmd),
		.cmd_empty (cmd_empty),
		.cmd_rd    (cmd_rd),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.is_status (is_status),
		.status    (status),
		.run_last  (run_last)
	);

endmodule

`default_nettype wire
